>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define GCE_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("glyph color expand assertion failed");

// next-cycle implication, held off during reset
`define GCE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("glyph color expand assertion failed");

`endif

>>> hdl/gce_pkg.sv
// ----------------------------------------------------------------------------
// gce_pkg
// types and constants of the glyph color expansion blitter
// ----------------------------------------------------------------------------
`default_nettype none

package gce_pkg;

  // default glyph size limit and fixed pixel format
  localparam int MaxGlyphDim   = 64;
  localparam int BytesPerPixel = 3;
  localparam int BitsPerByte   = 8;

  // field widths
  localparam int CoordW = 12;
  localparam int SizeW  = 7;
  localparam int ColorW = 24;
  localparam int AddrW  = 32;
  localparam int CfgW   = 32;
  localparam int CfgIdxW = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_FB_BASE       = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SCREEN_WIDTH  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SCREEN_HEIGHT = 2'd2;

  // configuration reset values
  localparam logic [CoordW-1:0] ScreenWidthRst  = 12'd640;
  localparam logic [CoordW-1:0] ScreenHeightRst = 12'd480;

  // input transaction
  typedef struct packed {
    logic [BitsPerByte-1:0] bitmap_byte;
    logic                   glyph_start;
    logic [CoordW-1:0]      glyph_x;
    logic [CoordW-1:0]      glyph_y;
    logic [SizeW-1:0]       glyph_width;
    logic [SizeW-1:0]       glyph_height;
    logic [ColorW-1:0]      glyph_color;
  } gce_in_t;

  // output transaction
  typedef struct packed {
    logic [AddrW-1:0]  pixel_addr;
    logic [ColorW-1:0] pixel_color;
    logic              last;
  } gce_out_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_WALK,
    ST_DRAIN
  } gce_state_e;

endpackage

`default_nettype wire

>>> hdl/glyph_color_expand_top.sv
// ----------------------------------------------------------------------------
// glyph_color_expand_top
// expands 1-bit glyph bitmap bytes into 24-bit framebuffer pixel writes
// ----------------------------------------------------------------------------
// One bitmap byte is taken at a time. After the byte is accepted the block
// forms the line offset (y times screen width) in its single 13x12
// multiplier, then walks the eight bits one per cycle, unless the output side
// stalls, through the shared address adder, then releases the final write,
// and takes the next byte in the cycle after that. The walk ends early when
// the glyph ends inside the byte and is skipped when no glyph is live. A set
// bit waits while the held write cannot move on because the output side
// stalls. At most one pixel write leaves per cycle. A write is held back one
// step so that the last write of each byte carries its last flag. The block
// takes the next byte while the final write of the previous one still waits
// in the output register. No clearing pass follows reset.
`default_nettype none

module glyph_color_expand_top
  import gce_pkg::*;
#(
  parameter int MAX_GLYPH_DIM = gce_pkg::MaxGlyphDim
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration writes
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i,
  // bitmap bytes
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire gce_in_t            in_data_i,
  // pixel writes
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output gce_out_t                out_data_o
);

  localparam int DimW  = $clog2(MAX_GLYPH_DIM + 1);
  localparam int PosW  = CoordW + 1;
  localparam int ProdW = PosW + CoordW;
  localparam int CntW  = $clog2(BitsPerByte);

  // configuration registers
  logic [AddrW-1:0]  fb_base_q;
  logic [CoordW-1:0] screen_width_q, screen_height_q;

  // sequencer and glyph state
  gce_state_e        state_q, state_d;
  logic              live_q, live_d;
  logic [DimW-1:0]   cur_row_q, cur_row_d, cur_col_q, cur_col_d;
  logic [CoordW-1:0] org_x_q, org_x_d, org_y_q, org_y_d;
  logic [DimW-1:0]   size_w_q, size_w_d, size_h_q, size_h_d;
  logic [ColorW-1:0] color_q, color_d;
  logic [BitsPerByte-1:0] bits_q, bits_d;
  logic [CntW-1:0]   bit_cnt_q, bit_cnt_d;
  logic [AddrW-1:0]  row_off_q, row_off_d;

  // held write and output register
  logic              hold_valid_q, hold_valid_d;
  logic [AddrW-1:0]  hold_addr_q, hold_addr_d;
  logic [ColorW-1:0] hold_color_q, hold_color_d;
  logic              out_valid_q, out_valid_d;
  gce_out_t          out_q, out_d;

  // datapath helpers
  logic [DimW-1:0]   w_clamp, h_clamp;
  logic              start_live;
  logic [PosW-1:0]   px, py;
  logic [ProdW-1:0]  prod;
  logic [AddrW-1:0]  lin, pix_addr;
  logic              hit, out_free;
  logic [DimW-1:0]   col_next, row_next;

  // configuration write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_base_q       <= '0;
      screen_width_q  <= ScreenWidthRst;
      screen_height_q <= ScreenHeightRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FB_BASE:       fb_base_q       <= cfg_wdata_i;
        CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_wdata_i[CoordW-1:0];
        CFG_SCREEN_HEIGHT: screen_height_q <= cfg_wdata_i[CoordW-1:0];
        default: ;
      endcase
    end
  end

  // glyph size saturation and start check
  always_comb begin
    if (32'(in_data_i.glyph_width) > 32'(MAX_GLYPH_DIM)) begin
      w_clamp = DimW'(MAX_GLYPH_DIM);
    end else begin
      w_clamp = DimW'(in_data_i.glyph_width);
    end
    if (32'(in_data_i.glyph_height) > 32'(MAX_GLYPH_DIM)) begin
      h_clamp = DimW'(MAX_GLYPH_DIM);
    end else begin
      h_clamp = DimW'(in_data_i.glyph_height);
    end
    start_live = (w_clamp != '0) && (h_clamp != '0) &&
                 (in_data_i.glyph_x < screen_width_q) &&
                 (in_data_i.glyph_y < screen_height_q);
  end

  // shared address path: pixel position, line multiply, byte address
  assign px       = {1'b0, org_x_q} + PosW'(cur_col_q);
  assign py       = {1'b0, org_y_q} + PosW'(cur_row_q);
  assign prod     = py * {1'b0, screen_width_q};
  assign lin      = row_off_q + AddrW'(px);
  assign pix_addr = fb_base_q + lin * AddrW'(BytesPerPixel);
  assign hit      = live_q && bits_q[BitsPerByte-1] &&
                    (px < {1'b0, screen_width_q}) && (py < {1'b0, screen_height_q});
  assign out_free = !out_valid_q || out_ready_i;
  assign col_next = cur_col_q + DimW'(1);
  assign row_next = cur_row_q + DimW'(1);

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      live_q       <= 1'b0;
      cur_row_q    <= '0;
      cur_col_q    <= '0;
      bit_cnt_q    <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      live_q       <= live_d;
      cur_row_q    <= cur_row_d;
      cur_col_q    <= cur_col_d;
      bit_cnt_q    <= bit_cnt_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    org_x_q      <= org_x_d;
    org_y_q      <= org_y_d;
    size_w_q     <= size_w_d;
    size_h_q     <= size_h_d;
    color_q      <= color_d;
    bits_q       <= bits_d;
    row_off_q    <= row_off_d;
    hold_addr_q  <= hold_addr_d;
    hold_color_q <= hold_color_d;
    out_q        <= out_d;
  end

  // sequencer: next state and datapath control
  always_comb begin
    state_d      = state_q;
    live_d       = live_q;
    cur_row_d    = cur_row_q;
    cur_col_d    = cur_col_q;
    org_x_d      = org_x_q;
    org_y_d      = org_y_q;
    size_w_d     = size_w_q;
    size_h_d     = size_h_q;
    color_d      = color_q;
    bits_d       = bits_q;
    bit_cnt_d    = bit_cnt_q;
    row_off_d    = row_off_q;
    hold_valid_d = hold_valid_q;
    hold_addr_d  = hold_addr_q;
    hold_color_d = hold_color_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    in_ready_o   = (state_q == ST_IDLE);

    // output transaction taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          bits_d    = in_data_i.bitmap_byte;
          bit_cnt_d = '0;
          if (in_data_i.glyph_start) begin
            org_x_d   = in_data_i.glyph_x;
            org_y_d   = in_data_i.glyph_y;
            size_w_d  = w_clamp;
            size_h_d  = h_clamp;
            color_d   = in_data_i.glyph_color;
            cur_row_d = '0;
            cur_col_d = '0;
            live_d    = start_live;
          end
          state_d = ST_MUL;
        end
      end

      // line offset of the current row
      ST_MUL: begin
        row_off_d = AddrW'(prod);
        state_d   = ST_WALK;
      end

      // one bitmap bit per cycle while the output side does not stall
      ST_WALK: begin
        if (!live_q) begin
          state_d = ST_DRAIN;
        end else if (!(hit && hold_valid_q && !out_free)) begin
          if (hit) begin
            if (hold_valid_q) begin
              out_d.pixel_addr  = hold_addr_q;
              out_d.pixel_color = hold_color_q;
              out_d.last        = 1'b0;
              out_valid_d       = 1'b1;
            end
            hold_valid_d = 1'b1;
            hold_addr_d  = pix_addr;
            hold_color_d = color_q;
          end
          bits_d    = bits_q << 1;
          bit_cnt_d = bit_cnt_q + CntW'(1);
          if (col_next >= size_w_q) begin
            cur_col_d = '0;
            cur_row_d = row_next;
            row_off_d = row_off_q + AddrW'(screen_width_q);
            if (row_next >= size_h_q) begin
              cur_row_d = '0;
              live_d    = 1'b0;
            end
          end else begin
            cur_col_d = col_next;
          end
          if (bit_cnt_q == CntW'(BitsPerByte - 1)) begin
            state_d = ST_DRAIN;
          end
        end
      end

      // release the held write as the last of this byte
      ST_DRAIN: begin
        if (!hold_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_d.pixel_addr  = hold_addr_q;
          out_d.pixel_color = hold_color_q;
          out_d.last        = 1'b1;
          out_valid_d       = 1'b1;
          hold_valid_d      = 1'b0;
          state_d           = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> hdl/gce_checker.sv
// ----------------------------------------------------------------------------
// gce_checker
// port-level checks of the glyph color expansion blitter
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gce_checker
  import gce_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_ready_o,
  input wire logic     out_valid_o,
  input wire logic     out_ready_i,
  input wire gce_out_t out_data_o
);

  logic out_stall;
  logic in_take;
  logic out_mid;

  assign out_stall = out_valid_o && !out_ready_i;
  assign in_take   = in_valid_i && in_ready_o;
  assign out_mid   = out_valid_o && !out_data_o.last;

  // a stalled output transaction keeps its payload
  `GCE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_data_o))

  // a byte keeps the block busy for at least the next cycle
  `GCE_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_take, !in_ready_o)

  // while a write that is not the last of its byte is shown, the byte is still at work
  `GCE_ASSERT_IMPL(a_not_last_busy, clk_i, rst_ni, out_mid, !in_ready_o)

endmodule

bind glyph_color_expand_top gce_checker u_gce_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
